/* hw/rtl/abl_pkg.sv */
// ----------------------------------------------------------------------------
// abl_pkg
// shared types and constants of the atlas block allocator
// ----------------------------------------------------------------------------
package abl_pkg;

	// block geometry, fixed by the pixel field widths
	localparam int BLOCK_SIZE = 32;
	localparam int BLK_SHIFT  = 5;

	// field widths
	localparam int DIM_W    = 12;                   // pixel sizes and register values
	localparam int SPAN_W   = DIM_W - BLK_SHIFT + 1; // block span of a request
	localparam int POS_W    = 11;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [DIM_W-1:0] ATLAS_DIM_RST = 12'd2048;

	typedef enum logic [STATUS_W-1:0] {
		ST_PLACED = 2'd0,
		ST_TOO_BIG = 2'd1,
		ST_FULL = 2'd2
	} abl_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATLAS_WIDTH = 1'b0,
		CFG_ATLAS_HEIGHT = 1'b1
	} abl_cfg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic ld_req;     // latch request and grid size
		logic row_init;   // start checking candidate row
		logic rd_row;     // read one span row into the union
		logic scan_step;  // advance the column scan
		logic next_row;   // move to the next candidate row
		logic hit;        // record the placement corner
		logic mark_rd;    // read a row to be marked
		logic mark_wr;    // write the marked row back
		logic out_load;   // hand the result to the output register
	} abl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic too_big;
		logic row_fits;
		logic rd_last;
		logic scan_end;
		logic scan_hit;
		logic span_empty;
		logic mk_last;
	} abl_sts_t;

endpackage

/* hw/rtl/abl_ctrl.sv */
// ----------------------------------------------------------------------------
// abl_ctrl
// sequencer of the allocator: row by row check, column scan, marking
// ----------------------------------------------------------------------------
module abl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_free,
	input  abl_pkg::abl_sts_t sts,
	output logic              in_ready,
	output abl_pkg::abl_cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CHK   = 9'b000000010,
		ST_ROW   = 9'b000000100,
		ST_RD    = 9'b000001000,
		ST_DRAIN = 9'b000010000,
		ST_SCAN  = 9'b000100000,
		ST_MRD   = 9'b001000000,
		ST_MWR   = 9'b010000000,
		ST_RES   = 9'b100000000
	} abl_state_t;

	abl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_req = 1'b1;
					state_d    = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = sts.too_big ? ST_RES : ST_ROW;
			end
			ST_ROW: begin
				if (sts.row_fits) begin
					cmd.row_init = 1'b1;
					state_d      = ST_RD;
				end else begin
					state_d = ST_RES;
				end
			end
			ST_RD: begin
				cmd.rd_row = 1'b1;
				if (sts.rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last row read lands in the union
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_end) begin
					cmd.next_row = 1'b1;
					state_d      = ST_ROW;
				end else if (sts.scan_hit) begin
					cmd.hit = 1'b1;
					state_d = sts.span_empty ? ST_RES : ST_MRD;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_MRD: begin
				cmd.mark_rd = 1'b1;
				state_d     = ST_MWR;
			end
			ST_MWR: begin
				cmd.mark_wr = 1'b1;
				if (sts.mk_last) begin
					state_d = ST_RES;
				end else begin
					state_d = ST_MRD;
				end
			end
			ST_RES: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	a_cmd_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_ld_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_req |=> (state_q == ST_CHK))
		else $error("request load did not start a check");

	a_mark_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_rd |=> cmd.mark_wr)
		else $error("row read for marking not followed by its write");

endmodule

/* hw/rtl/abl_dp.sv */
// ----------------------------------------------------------------------------
// abl_dp
// allocator datapath: occupancy rows, span union, column scan, marking
// ----------------------------------------------------------------------------
module abl_dp #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  abl_pkg::abl_cmd_t            cmd,
	input  logic [abl_pkg::DIM_W-1:0]    atlas_width,
	input  logic [abl_pkg::DIM_W-1:0]    atlas_height,
	input  logic [abl_pkg::DIM_W-1:0]    rect_width,
	input  logic [abl_pkg::DIM_W-1:0]    rect_height,
	output abl_pkg::abl_sts_t            sts,
	output logic [abl_pkg::STATUS_W-1:0] res_status,
	output logic [abl_pkg::POS_W-1:0]    res_x,
	output logic [abl_pkg::POS_W-1:0]    res_y
);

	localparam int CI_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RI_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CN   = $clog2(MAX_COLS + 1);
	localparam int RN   = $clog2(MAX_ROWS + 1);
	localparam int CW   = ((CN > abl_pkg::SPAN_W) ? CN : abl_pkg::SPAN_W) + 1;
	localparam int RW   = ((RN > abl_pkg::SPAN_W) ? RN : abl_pkg::SPAN_W) + 1;
	localparam int SH   = abl_pkg::BLK_SHIFT;
	localparam int DW   = abl_pkg::DIM_W;

	// occupancy rows with a valid bit per row, so reset reads all free
	logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
	logic [MAX_ROWS-1:0] row_vld_q;
	logic [MAX_COLS-1:0] rd_data_q;
	logic                rd_vld_q;
	logic                rd_pend_q;

	logic [abl_pkg::SPAN_W-1:0] sx_q, sy_q;
	logic [CW-1:0]              cols_q, c_q, run_q;
	logic [RW-1:0]              rows_q, r_q, k_q;
	logic                       too_big_q;
	logic [MAX_COLS-1:0]        acc_q, mask_q;
	logic [CI_W-1:0]            col_q;
	abl_pkg::abl_status_t       code_q;

	logic [CW-1:0]              sxe, cols_d;
	logic [RW-1:0]              sye, rde, rows_d, row_sum;
	logic [RI_W-1:0]            row_addr;
	logic [MAX_COLS-1:0]        row_rd, mask_d;
	logic [DW:0]                sx_sum, sy_sum;
	logic                       cur_bit;
	logic                       span_empty;

	assign span_empty = (sx_q == '0) || (sy_q == '0);

	// an empty span only needs its corner cell free, so the scan looks
	// for a single free cell in the corner row; the bounds still use the span
	assign sxe = span_empty ? CW'(1) : CW'(sx_q);
	assign sye = (sy_q == '0) ? RW'(1) : RW'(sy_q);
	assign rde = span_empty ? RW'(1) : RW'(sy_q);

	assign cols_d = (CW'(atlas_width[DW-1:SH]) > CW'(MAX_COLS)) ?
		CW'(MAX_COLS) : CW'(atlas_width[DW-1:SH]);
	assign rows_d = (RW'(atlas_height[DW-1:SH]) > RW'(MAX_ROWS)) ?
		RW'(MAX_ROWS) : RW'(atlas_height[DW-1:SH]);

	assign sx_sum = {1'b0, rect_width} + (DW + 1)'(abl_pkg::BLOCK_SIZE - 1);
	assign sy_sum = {1'b0, rect_height} + (DW + 1)'(abl_pkg::BLOCK_SIZE - 1);

	assign row_sum  = r_q + k_q;
	assign row_addr = row_sum[RI_W-1:0];
	assign row_rd   = rd_vld_q ? rd_data_q : '0;
	assign cur_bit  = acc_q[c_q[CI_W-1:0]];

	always_comb begin
		for (int j = 0; j < MAX_COLS; j++) begin
			mask_d[j] = (CW'(j) >= CW'(col_q)) && (CW'(j) < (CW'(col_q) + CW'(sx_q)));
		end
	end

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.mark_wr) begin
			mem_q[row_addr] <= row_rd | mask_q;
		end
		if (cmd.rd_row || cmd.mark_rd) begin
			rd_data_q <= mem_q[row_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= cmd.rd_row;
			if (cmd.rd_row || cmd.mark_rd) begin
				rd_vld_q <= row_vld_q[row_addr];
			end
			if (cmd.mark_wr) begin
				row_vld_q[row_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			sx_q      <= sx_sum[DW:SH];
			sy_q      <= sy_sum[DW:SH];
			cols_q    <= cols_d;
			rows_q    <= rows_d;
			too_big_q <= (rect_width > atlas_width) || (rect_height > atlas_height);
			code_q    <= ((rect_width > atlas_width) || (rect_height > atlas_height)) ?
				abl_pkg::ST_TOO_BIG : abl_pkg::ST_FULL;
			r_q       <= '0;
		end
		if (cmd.row_init) begin
			k_q   <= '0;
			c_q   <= '0;
			run_q <= '0;
		end
		if (cmd.rd_row || cmd.mark_wr) begin
			k_q <= k_q + RW'(1);
		end
		// union of the span rows
		if (cmd.row_init) begin
			acc_q <= '0;
		end else if (rd_pend_q) begin
			acc_q <= acc_q | row_rd;
		end
		if (cmd.scan_step) begin
			run_q <= cur_bit ? '0 : run_q + CW'(1);
			c_q   <= c_q + CW'(1);
		end
		if (cmd.next_row) begin
			r_q <= r_q + RW'(1);
		end
		if (cmd.hit) begin
			col_q  <= CI_W'(c_q + CW'(1) - sxe);
			k_q    <= '0;
			code_q <= abl_pkg::ST_PLACED;
		end
		if (cmd.mark_rd) begin
			mask_q <= mask_d;
		end
	end

	assign sts.too_big    = too_big_q;
	assign sts.row_fits   = (r_q + sye) <= rows_q;
	assign sts.rd_last    = (k_q + RW'(1)) == rde;
	// an empty span scans start columns and must still end inside the grid
	assign sts.scan_end   = (c_q >= cols_q) ||
		(span_empty && ((c_q + CW'(sx_q)) > cols_q));
	assign sts.scan_hit   = !cur_bit && ((run_q + CW'(1)) == sxe);
	assign sts.span_empty = span_empty;
	assign sts.mk_last    = (k_q + RW'(1)) == RW'(sy_q);

	assign res_status = code_q;
	assign res_x = (code_q == abl_pkg::ST_PLACED) ? (abl_pkg::POS_W'(col_q) << SH) : '0;
	assign res_y = (code_q == abl_pkg::ST_PLACED) ? (abl_pkg::POS_W'(r_q) << SH) : '0;

	a_mark_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_wr |-> (row_sum < rows_q))
		else $error("marking a row outside the grid");

	a_mask_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_wr |-> ((mask_q >> cols_q) == '0))
		else $error("marking a column outside the grid");

	a_hit_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit |-> ((c_q + CW'(1)) >= sxe))
		else $error("placement column underflow");

endmodule

/* hw/rtl/atlas_block_allocator.sv */
// ----------------------------------------------------------------------------
// atlas_block_allocator
// first-fit rectangle placement on a grid of 32-pixel atlas blocks
// ----------------------------------------------------------------------------
//
//  channel | signals                       | word
//  --------+-------------------------------+----------------------------------
//  s_      | s_tvalid s_tready s_tdata     | rect_width, rect_height
//  m_      | m_tvalid m_tready m_tdata     | status, pos_x, pos_y
//  cfg_    | cfg_valid cfg_ready cfg_index | atlas_width (0), atlas_height (1)
//          | cfg_data                      |
//
// one request at a time; each candidate row reads the span rows one by one through
// the single read port of the occupancy row memory, then scans the columns
// (rows read is the span height, or one for an empty span)
// placing reads each covered row, then writes it back
// reset clears only per-row valid bits, so no clearing pass is needed
// the result sits in an output register; a new word is taken while it waits
//
module atlas_block_allocator #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,   // rect_width[11:0], rect_height[23:12]
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // status[1:0], pos_x[12:2], pos_y[23:13]
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [abl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [abl_pkg::DIM_W-1:0]     cfg_data
);

	abl_pkg::abl_cmd_t            cmd;
	abl_pkg::abl_sts_t            sts;
	logic [abl_pkg::DIM_W-1:0]    atlas_width_q, atlas_height_q;
	logic [abl_pkg::STATUS_W-1:0] res_status;
	logic [abl_pkg::POS_W-1:0]    res_x, res_y;
	logic                         out_vld_q;
	logic [23:0]                  out_data_q;
	logic                         out_free;

	// registers are always writable; a request takes its copy when accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_width_q  <= abl_pkg::ATLAS_DIM_RST;
			atlas_height_q <= abl_pkg::ATLAS_DIM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				abl_pkg::CFG_ATLAS_WIDTH:  atlas_width_q  <= cfg_data;
				abl_pkg::CFG_ATLAS_HEIGHT: atlas_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// output register, refilled in the cycle it drains
	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {res_y, res_x, res_status};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	abl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	abl_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.atlas_width  (atlas_width_q),
		.atlas_height (atlas_height_q),
		.rect_width   (s_tdata[11:0]),
		.rect_height  (s_tdata[23:12]),
		.sts          (sts),
		.res_status   (res_status),
		.res_x        (res_x),
		.res_y        (res_y)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result loaded over an unaccepted word");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not offered");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> cmd.ld_req)
		else $error("request accepted without being loaded");

endmodule
